// ===== rtl/idq_pkg.sv =====
// Shared types and constants for the indexed deque.
// Used by idq_cell and indexed_deque; depends on nothing else.
package idq_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_TAKE_FRONT = 3'd2,
        OP_TAKE_BACK  = 3'd3,
        OP_TAKE_AT    = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COLLECT,
        ST_APPLY
    } state_t;

    localparam logic [1:0] STATUS_DONE = 2'd0;
    localparam logic [1:0] STATUS_MISS = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    localparam logic [DATA_W-1:0] VALUE_NONE = {DATA_W{1'b1}};

    // Commands broadcast to every cell of the chain.
    typedef struct packed {
        logic push_front;  // every cell takes its front neighbor's data
        logic push_back;   // the selected cell loads the new value
        logic remove;      // cells at or behind the selected one take their back neighbor
        logic collect;     // tap chain moves one cell toward the front
        logic clear_tap;   // tap chain is emptied
    } cell_ctrl_t;

endpackage

// ===== rtl/idq_cell.sv =====
// One storage cell of the deque chain: an entry register and a tap register.
// Depends on idq_pkg for the command struct and data width.
module idq_cell #(
    parameter int INDEX = 0,
    parameter int IDX_W = 4
) (
    input  logic                       clk,
    input  idq_pkg::cell_ctrl_t        ctrl,
    input  logic [IDX_W-1:0]           sel,
    input  logic [idq_pkg::DATA_W-1:0] value_in,
    input  logic [idq_pkg::DATA_W-1:0] prev_data,
    input  logic [idq_pkg::DATA_W-1:0] next_data,
    input  logic [idq_pkg::DATA_W-1:0] next_tap,
    output logic [idq_pkg::DATA_W-1:0] data,
    output logic [idq_pkg::DATA_W-1:0] tap
);

    logic [idq_pkg::DATA_W-1:0] data_reg;
    logic [idq_pkg::DATA_W-1:0] data_next;
    logic [idq_pkg::DATA_W-1:0] tap_reg;
    logic [idq_pkg::DATA_W-1:0] tap_next;
    logic                       hit;
    logic                       at_or_behind;

    assign hit          = (sel == IDX_W'(INDEX));
    assign at_or_behind = (sel <= IDX_W'(INDEX));

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.push_front)
        begin
            data_next = prev_data;
        end
        else if (ctrl.push_back && hit)
        begin
            data_next = value_in;
        end
        else if (ctrl.remove && at_or_behind)
        begin
            data_next = next_data;
        end
    end

    // The tap chain carries the selected entry toward the front, one cell a cycle.
    always_comb
    begin
        tap_next = tap_reg;
        if (ctrl.clear_tap)
        begin
            tap_next = '0;
        end
        else if (ctrl.collect)
        begin
            tap_next = next_tap | (hit ? data_reg : '0);
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        tap_reg  <= tap_next;
    end

    assign data = data_reg;
    assign tap  = tap_reg;

endmodule

// ===== rtl/indexed_deque.sv =====
// Indexed deque: a bounded ordered store of signed 32-bit entries, position 0 at the front,
// built as a chain of DEPTH cells. Pushes at either end, refusals and errors have their
// result in the cycle after the transaction. A removal at position p (front: p = 0, back:
// p = count - 1) goes through COLLECT, where the tap chain walks the selected entry to the
// front one cell per cycle, then APPLY, where the cells close the gap in a single shift once
// the result slot is free. One item is in work at a time; the result register lets the next
// item in while the downstream side takes the last result. Every result carries the value
// taken out (-1 when none), a status and the count. Depends on idq_pkg and idq_cell.
module indexed_deque #(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [31:0] value_in, [35:32] position, [39:36] zero
    input  logic [2:0]  s_axis_tuser,   // [2:0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] value_out, [36:32] occupancy, [39:37] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
    localparam int OCC_W = (CNT_W > 5) ? CNT_W : 5;
    localparam int DW    = idq_pkg::DATA_W;

    idq_pkg::state_t     state_reg;
    idq_pkg::state_t     state_next;
    idq_pkg::cell_ctrl_t ctrl;
    idq_pkg::op_t        op;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] pos_reg;
    logic [IDX_W-1:0] pos_next;
    logic [IDX_W-1:0] steps_reg;
    logic [IDX_W-1:0] steps_next;
    logic [IDX_W-1:0] sel;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [DW-1:0]    out_value_reg;
    logic [DW-1:0]    out_value_next;
    logic [1:0]       out_status_reg;
    logic [1:0]       out_status_next;
    logic [4:0]       out_occ_reg;
    logic [4:0]       out_occ_next;
    logic             out_load;

    logic             accept;
    logic             slot_free;
    logic             is_full;
    logic             is_empty;
    logic             start_take;
    logic [CMP_W-1:0] position_ext;
    logic [CMP_W-1:0] count_ext;
    logic [OCC_W-1:0] occ_ext;
    logic [DW-1:0]    value_in;
    logic [3:0]       position;

    logic [DW-1:0]    data_w [DEPTH];
    logic [DW-1:0]    tap_w  [DEPTH+1];

    assign value_in  = s_axis_tdata[31:0];
    assign position  = s_axis_tdata[35:32];
    assign op        = idq_pkg::op_t'(s_axis_tuser);

    assign slot_free     = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == idq_pkg::ST_IDLE) && slot_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign is_full      = (count_reg == CNT_W'(DEPTH));
    assign is_empty     = (count_reg == '0);
    assign position_ext = CMP_W'(position);
    assign count_ext    = CMP_W'(count_reg);

    // An accepted removal that finds an entry starts the tap walk.
    always_comb
    begin
        start_take = 1'b0;
        case (op)
            idq_pkg::OP_TAKE_FRONT,
            idq_pkg::OP_TAKE_BACK: start_take = !is_empty;
            idq_pkg::OP_TAKE_AT:   start_take = (position_ext < count_ext);
            default:               start_take = 1'b0;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            idq_pkg::ST_IDLE:
            begin
                if (accept && start_take)
                begin
                    state_next = idq_pkg::ST_COLLECT;
                end
            end
            idq_pkg::ST_COLLECT:
            begin
                if (steps_reg == '0)
                begin
                    state_next = idq_pkg::ST_APPLY;
                end
            end
            idq_pkg::ST_APPLY:
            begin
                if (slot_free)
                begin
                    state_next = idq_pkg::ST_IDLE;
                end
            end
            default: state_next = idq_pkg::ST_IDLE;
        endcase
    end

    // Datapath control and result loading.
    always_comb
    begin
        ctrl            = '0;
        sel             = pos_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        steps_next      = steps_reg;
        out_load        = 1'b0;
        out_value_next  = idq_pkg::VALUE_NONE;
        out_status_next = idq_pkg::STATUS_DONE;
        case (state_reg)
            idq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        idq_pkg::OP_PUSH_BACK:
                        begin
                            out_load = 1'b1;
                            if (is_full)
                            begin
                                out_status_next = idq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                ctrl.push_back = 1'b1;
                                sel            = count_reg[IDX_W-1:0];
                                count_next     = count_reg + CNT_W'(1);
                            end
                        end
                        idq_pkg::OP_PUSH_FRONT:
                        begin
                            out_load = 1'b1;
                            if (is_full)
                            begin
                                out_status_next = idq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                ctrl.push_front = 1'b1;
                                count_next      = count_reg + CNT_W'(1);
                            end
                        end
                        idq_pkg::OP_TAKE_FRONT:
                        begin
                            pos_next = '0;
                        end
                        idq_pkg::OP_TAKE_BACK:
                        begin
                            pos_next = IDX_W'(count_reg - CNT_W'(1));
                        end
                        idq_pkg::OP_TAKE_AT:
                        begin
                            pos_next = position_ext[IDX_W-1:0];
                        end
                        default:
                        begin
                            out_load        = 1'b1;
                            out_status_next = idq_pkg::STATUS_MISS;
                        end
                    endcase
                    if (start_take)
                    begin
                        ctrl.clear_tap = 1'b1;
                        steps_next     = pos_next;
                    end
                    else if (op == idq_pkg::OP_TAKE_FRONT || op == idq_pkg::OP_TAKE_BACK
                             || op == idq_pkg::OP_TAKE_AT)
                    begin
                        out_load        = 1'b1;
                        out_status_next = idq_pkg::STATUS_MISS;
                    end
                end
            end
            idq_pkg::ST_COLLECT:
            begin
                ctrl.collect = 1'b1;
                steps_next   = steps_reg - IDX_W'(1);
            end
            idq_pkg::ST_APPLY:
            begin
                if (slot_free)
                begin
                    ctrl.remove    = 1'b1;
                    count_next     = count_reg - CNT_W'(1);
                    out_load       = 1'b1;
                    out_value_next = tap_w[0];
                end
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    assign occ_ext      = OCC_W'(count_next);
    assign out_occ_next = occ_ext[4:0];

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= idq_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        steps_reg <= steps_next;
        if (out_load)
        begin
            out_value_reg  <= out_value_next;
            out_status_reg <= out_status_next;
            out_occ_reg    <= out_occ_next;
        end
    end

    assign tap_w[DEPTH] = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DW-1:0] prev_d;
        logic [DW-1:0] next_d;

        if (i == 0)
        begin : g_front
            assign prev_d = value_in;
        end
        else
        begin : g_mid
            assign prev_d = data_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_back
            assign next_d = '0;
        end
        else
        begin : g_inner
            assign next_d = data_w[i+1];
        end

        idq_cell #(
            .INDEX (i),
            .IDX_W (IDX_W)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .sel       (sel),
            .value_in  (value_in),
            .prev_data (prev_d),
            .next_data (next_d),
            .next_tap  (tap_w[i+1]),
            .data      (data_w[i]),
            .tap       (tap_w[i])
        );
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_occ_reg, out_value_reg};
    assign m_axis_tuser  = out_status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above capacity");

    a_apply_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == idq_pkg::ST_APPLY && slot_free) |=>
            (m_axis_tvalid && m_axis_tuser == idq_pkg::STATUS_DONE
             && state_reg == idq_pkg::ST_IDLE))
        else $error("removal did not deliver a done result");

    a_apply_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == idq_pkg::ST_APPLY && slot_free) |=>
            (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("removal did not lower the count");

    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_full && (s_axis_tuser == 3'(idq_pkg::OP_PUSH_BACK)
                               || s_axis_tuser == 3'(idq_pkg::OP_PUSH_FRONT))) |=>
            ($stable(count_reg) && m_axis_tuser == idq_pkg::STATUS_FULL))
        else $error("push into a full store was not refused");

endmodule

// ===== tb/indexed_deque_tb.sv =====
// Self-checking testbench for indexed_deque: directed corner cases, then random deque traffic
// under several idle and stall patterns, checked against an in-bench shadow of the deque.
// Depends on idq_pkg and the indexed_deque RTL.
`timescale 1ns / 1ps

module indexed_deque_tb;

    localparam int DEPTH = 16;
    localparam int CLK_HALF = 6;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_PER_PHASE = 488;
    localparam int HOLD_CYCLES = 120;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS = 10;

    // Codes outside op_t that the block must answer with a miss.
    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_MID   = 3'd6;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

    localparam logic [31:0] VALUE_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] VALUE_MIN  = 32'h8000_0000;
    localparam logic [31:0] VALUE_ZERO = 32'h0000_0000;

    typedef struct {
        logic [2:0]  opcode;
        logic [31:0] value;
        logic [3:0]  pos;
    } deque_req_t;

    typedef struct {
        logic [31:0] value;
        logic [1:0]  status;
        logic [4:0]  count;
    } deque_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    deque_req_t    queued_requests[$];
    deque_result_t pending_outcomes[$];
    logic [31:0]   shadow_entries[$];

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   mismatch_count = 0;
    int   stim_count = 0;
    logic hold_go = 1'b0;
    logic recv_hold = 1'b0;

    indexed_deque #(
        .DEPTH(DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    initial
    begin
        forever #(CLK_HALF) clk = ~clk;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #5_000_000;
        $display("indexed_deque verification failed");
        $finish;
    end

    // Applies one operation to the shadow deque and returns what the block must answer.
    function automatic deque_result_t predict_outcome(logic [2:0] opcode, logic [31:0] value,
                                                      logic [3:0] pos);
        deque_result_t res;
        res.value = idq_pkg::VALUE_NONE;
        res.status = idq_pkg::STATUS_DONE;
        case (opcode)
            idq_pkg::OP_PUSH_BACK, idq_pkg::OP_PUSH_FRONT:
            begin
                if (shadow_entries.size() >= DEPTH)
                    res.status = idq_pkg::STATUS_FULL;
                else if (opcode == idq_pkg::OP_PUSH_BACK)
                    shadow_entries.push_back(value);
                else
                    shadow_entries.push_front(value);
            end
            idq_pkg::OP_TAKE_FRONT:
            begin
                if (shadow_entries.size() == 0)
                    res.status = idq_pkg::STATUS_MISS;
                else
                    res.value = shadow_entries.pop_front();
            end
            idq_pkg::OP_TAKE_BACK:
            begin
                if (shadow_entries.size() == 0)
                    res.status = idq_pkg::STATUS_MISS;
                else
                    res.value = shadow_entries.pop_back();
            end
            idq_pkg::OP_TAKE_AT:
            begin
                if (int'(pos) >= shadow_entries.size())
                    res.status = idq_pkg::STATUS_MISS;
                else
                begin
                    res.value = shadow_entries[pos];
                    shadow_entries.delete(int'(pos));
                end
            end
            default:
                res.status = idq_pkg::STATUS_MISS;
        endcase
        res.count = 5'(shadow_entries.size());
        return res;
    endfunction

    // The stimulus side keeps its own fill count only to steer positions.
    task automatic queue_request(logic [2:0] opcode, logic [31:0] value, logic [3:0] pos);
        deque_req_t req;
        req.opcode = opcode;
        req.value = value;
        req.pos = pos;
        queued_requests.push_back(req);
        case (opcode)
            idq_pkg::OP_PUSH_BACK, idq_pkg::OP_PUSH_FRONT:
                if (stim_count < DEPTH)
                    stim_count++;
            idq_pkg::OP_TAKE_FRONT, idq_pkg::OP_TAKE_BACK:
                if (stim_count > 0)
                    stim_count--;
            idq_pkg::OP_TAKE_AT:
                if (int'(pos) < stim_count)
                    stim_count--;
            default:
                ;
        endcase
    endtask

    task automatic queue_random_burst(int n_items);
        int          push_pct;
        int          r;
        logic [2:0]  opcode;
        logic [31:0] value;
        logic [3:0]  pos;
        push_pct = 50;
        for (int i = 0; i < n_items; i++)
        begin
            // A new push bias, drawn from 10 to 90 percent, every 64 transactions.
            if (i % 64 == 0)
                push_pct = $urandom_range(10, 90);
            r = $urandom_range(0, 99);
            if (r < 3)
                opcode = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
            else if ($urandom_range(0, 99) < push_pct)
                opcode = $urandom_range(0, 1) ? idq_pkg::OP_PUSH_BACK : idq_pkg::OP_PUSH_FRONT;
            else
            begin
                case ($urandom_range(0, 2))
                    0: opcode = idq_pkg::OP_TAKE_FRONT;
                    1: opcode = idq_pkg::OP_TAKE_BACK;
                    default: opcode = idq_pkg::OP_TAKE_AT;
                endcase
            end
            case ($urandom_range(0, 7))
                0: value = VALUE_MAX;
                1: value = VALUE_MIN;
                2: value = VALUE_ZERO;
                3: value = idq_pkg::VALUE_NONE;
                default: value = $urandom;
            endcase
            if (stim_count > 0 && $urandom_range(0, 9) != 0)
                pos = 4'($urandom_range(0, stim_count - 1));
            else
                pos = 4'($urandom_range(0, DEPTH - 1));
            queue_request(opcode, value, pos);
        end
    endtask

    task automatic wait_until_drained();
        while (queued_requests.size() != 0 || s_axis_tvalid || pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected 0x%08h, got 0x%08h", $realtime, what, want, got);
    endtask

    // Driver: predicts on every accepted transaction, then offers the next pending request.
    always @(posedge clk)
    begin : drive_proc
        deque_req_t next_req;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                pending_outcomes.push_back(predict_outcome(s_axis_tuser, s_axis_tdata[31:0],
                                                           s_axis_tdata[35:32]));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (queued_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_req = queued_requests.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= next_req.opcode;
                    s_axis_tdata <= {4'b0000, next_req.pos, next_req.value};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks each accepted result against the oldest prediction.
    always @(posedge clk)
    begin : check_proc
        deque_result_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_outcomes.size() == 0)
                    flag_mismatch("unexpected result", '0, m_axis_tdata[31:0]);
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (m_axis_tdata[31:0] !== want.value)
                        flag_mismatch("value_out", want.value, m_axis_tdata[31:0]);
                    if (m_axis_tuser !== want.status)
                        flag_mismatch("status", 32'(want.status), 32'(m_axis_tuser));
                    if (m_axis_tdata[36:32] !== want.count)
                        flag_mismatch("occupancy", 32'(want.count), 32'(m_axis_tdata[36:32]));
                end
            end
            m_axis_tready <= !recv_hold && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Long downstream hold-off so the result path backs up into the input side.
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        recv_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        recv_hold <= 1'b0;
    end

    initial
    begin
        @(posedge rst_n);
        @(negedge clk);

        // Empty store, unused codes, extremes of the value field and a position past the end.
        queue_request(idq_pkg::OP_TAKE_FRONT, VALUE_ZERO, 4'd0);
        queue_request(idq_pkg::OP_TAKE_BACK, idq_pkg::VALUE_NONE, 4'd15);
        queue_request(idq_pkg::OP_TAKE_AT, VALUE_ZERO, 4'd0);
        queue_request(OP_UNUSED_FIRST, VALUE_MAX, 4'd15);
        queue_request(OP_UNUSED_MID, VALUE_MIN, 4'd0);
        queue_request(OP_UNUSED_LAST, idq_pkg::VALUE_NONE, 4'd7);
        queue_request(idq_pkg::OP_PUSH_BACK, VALUE_MAX, 4'd0);
        queue_request(idq_pkg::OP_PUSH_FRONT, VALUE_MIN, 4'd15);
        queue_request(idq_pkg::OP_TAKE_AT, VALUE_ZERO, 4'd15);
        queue_request(idq_pkg::OP_TAKE_BACK, VALUE_ZERO, 4'd0);
        queue_request(idq_pkg::OP_TAKE_FRONT, VALUE_ZERO, 4'd0);
        // Fill to the brim, get refused at both ends, then take from the last and a middle slot.
        for (int i = 0; i < DEPTH; i++)
            queue_request((i % 2 == 0) ? idq_pkg::OP_PUSH_BACK : idq_pkg::OP_PUSH_FRONT,
                          (i % 3 == 0) ? idq_pkg::VALUE_NONE : 32'(i * 32'h1111_1111), 4'(i));
        queue_request(idq_pkg::OP_PUSH_BACK, VALUE_ZERO, 4'd0);
        queue_request(idq_pkg::OP_PUSH_FRONT, VALUE_MAX, 4'd0);
        queue_request(idq_pkg::OP_TAKE_AT, VALUE_ZERO, 4'd15);
        queue_request(idq_pkg::OP_TAKE_AT, VALUE_ZERO, 4'd7);
        wait_until_drained();

        for (int phase = 0; phase < 4; phase++)
        begin
            @(negedge clk);
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                    hold_go = 1'b1;
                end
                1:
                begin
                    send_idle_pct = 76;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 76;
                end
                default:
                begin
                    send_idle_pct = 20;
                    recv_stall_pct = 20;
                end
            endcase
            queue_random_burst(RANDOM_PER_PHASE);
            // The sender stays quiet here until every outstanding result is back.
            wait_until_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_outcomes.size() == 0)
            $display("indexed_deque verification clean");
        else
            $display("indexed_deque verification failed");
        $finish;
    end

endmodule
